// ===== sv/mono_text_display_tracker_unit_macros.svh =====
// assertion macros for the monochrome text display tracker
// used by the top level; expects signals clk and rst_n in the including scope
`ifndef MONO_TEXT_DISPLAY_TRACKER_UNIT_MACROS_SVH
`define MONO_TEXT_DISPLAY_TRACKER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mtd_pkg.sv =====
// shared types, codes and helper functions of the monochrome text display tracker
// no dependencies
`timescale 1ns / 1ps

package mtd_pkg;

  localparam int VRAM_BYTES_DEF    = 16384;
  localparam int COLS_DEF          = 80;
  localparam int VISIBLE_BYTES_DEF = 4000;

  localparam int POS_W  = 16;
  localparam int COLS_W = 8;

  localparam logic [1:0] CMD_VBYTE  = 2'd0;
  localparam logic [1:0] CMD_VWORD  = 2'd1;
  localparam logic [1:0] CMD_PWRITE = 2'd2;
  localparam logic [1:0] CMD_PREAD  = 2'd3;

  localparam logic [1:0] KIND_CELL   = 2'd0;
  localparam logic [1:0] KIND_CURSOR = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [13:0] PORT_DATA  = 14'd1;
  localparam logic [13:0] PORT_COUNT = 14'd16;
  localparam logic [3:0]  PORT_INDEX = 4'd0;

  localparam logic [7:0] CRTC_CUR_HI = 8'h0e;
  localparam logic [7:0] CRTC_CUR_LO = 8'h0f;

  localparam logic [6:0] GLYPH_SPACE = 7'd32;
  localparam logic [6:0] GLYPH_DOT   = 7'd46;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] col;
    logic [9:0] row;
    logic [6:0] glyph;
    logic       bright;
    logic       fg_on;
    logic       bg_on;
    logic [7:0] read_data;
  } result_t;

  typedef struct packed {
    logic              valid;
    logic [POS_W-1:0]  quo;
    logic [COLS_W-1:0] rem;
  } div_out_t;

  function automatic logic [6:0] shown_glyph(input logic [7:0] c);
    logic [6:0] g;
    if (c >= 8'd32 && !c[7]) begin
      g = c[6:0];
    end else if (c == 8'd0) begin
      g = GLYPH_SPACE;
    end else begin
      g = GLYPH_DOT;
    end
    return g;
  endfunction

endpackage

// ===== sv/mtd_ram.sv =====
// generic single-port synchronous ram, read-first, registered read
// no dependencies
`timescale 1ns / 1ps

module mtd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/mtd_div.sv =====
// three-stage divide of a 16-bit position by the column count
// reciprocal multiply, back-multiply, one correction step; uses mtd_pkg
`timescale 1ns / 1ps

module mtd_div
  import mtd_pkg::*;
#(
  parameter int COLS = COLS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [POS_W-1:0] num,
  output div_out_t         res
);

  localparam int RECIP = (1 << POS_W) / COLS;
  localparam int RW    = $clog2(RECIP + 1);
  localparam logic [RW-1:0]     RECIP_V = RW'(RECIP);
  localparam logic [COLS_W-1:0] COLS_V  = COLS_W'(COLS);

  logic              v1_r, v2_r;
  logic [POS_W-1:0]  p1_r, p2_r, m2_r;
  logic [RW-1:0]     q1_r, q2_r;
  div_out_t          res_r;

  logic [POS_W+RW-1:0]   prod1;
  logic [RW+COLS_W-1:0]  prod2;
  logic [POS_W-1:0]      diff;
  logic                  fix;
  logic [POS_W-1:0]      diff_fix;

  assign prod1    = {{RW{1'b0}}, num} * {{POS_W{1'b0}}, RECIP_V};
  assign prod2    = {{COLS_W{1'b0}}, q1_r} * {{RW{1'b0}}, COLS_V};
  assign diff     = p2_r - m2_r;
  assign fix      = diff >= {{(POS_W-COLS_W){1'b0}}, COLS_V};
  assign diff_fix = fix ? diff - {{(POS_W-COLS_W){1'b0}}, COLS_V} : diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      res_r.valid <= 1'b0;
    end else begin
      v1_r      <= start;
      v2_r      <= v1_r;
      res_r.valid <= v2_r;
    end
    p1_r      <= num;
    q1_r      <= prod1[POS_W+RW-1:POS_W];
    p2_r      <= p1_r;
    q2_r      <= q1_r;
    m2_r      <= prod2[POS_W-1:0];
    res_r.quo <= POS_W'(q2_r) + POS_W'(fix);
    res_r.rem <= diff_fix[COLS_W-1:0];
  end

  assign res = res_r;

endmodule

// ===== sv/mono_text_display_tracker_unit.sv =====
// top level of the monochrome text display tracker: sequencer, port store, cursor
// uses mtd_pkg, mtd_ram, mtd_div and the assertion macro header
`timescale 1ns / 1ps
`include "mono_text_display_tracker_unit_macros.svh"

// Watches bus accesses to a monochrome text adapter and reports cell updates, cursor
// moves and port read data, none, one or two results per input transaction, the last
// one flagged by out_last. Video RAM is held as words of two bytes (character,
// attribute) in one single-port ram with a registered read, so each byte write is a
// read, then a compare and write-back, with the cell position found by a three-stage
// divide by COLS. After reset the ram is cleared one word a cycle, all (VRAM_BYTES+1)/2
// words (8192 at the default size), with in_stall high. One transaction at a time is
// worked on: a port read pushes its result, a port write that moves the cursor and a
// video byte write that changes a visible cell go through the divide before the push,
// a word write handles its bytes in turn, and results wait on out_stall.
module mono_text_display_tracker_unit
  import mtd_pkg::*;
#(
  parameter int VRAM_BYTES    = VRAM_BYTES_DEF,
  parameter int COLS          = COLS_DEF,
  parameter int VISIBLE_BYTES = VISIBLE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [13:0] in_addr,
  input  logic [15:0] in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [6:0]  out_col,
  output logic [9:0]  out_row,
  output logic [6:0]  out_glyph,
  output logic        out_bright,
  output logic        out_fg_on,
  output logic        out_bg_on,
  output logic [7:0]  out_read_data,
  output logic        out_last
);

  localparam int WORDS = (VRAM_BYTES + 1) / 2;
  localparam int WAW   = $clog2(WORDS);
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
  localparam logic [16:0]    VRAM_LIM  = 17'(VRAM_BYTES);
  localparam logic [14:0]    VIS_LIM   = 15'(VISIBLE_BYTES);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_MOD, S_DIV, S_PUSH} state_t;

  state_t          state_r, state_nxt;
  logic [WAW-1:0]  clr_idx_r, clr_idx_nxt;
  logic [1:0]      cmd_r, cmd_nxt;
  logic [13:0]     addr_r, addr_nxt;
  logic [15:0]     data_r, data_nxt;
  logic            byte_sel_r, byte_sel_nxt;
  logic [1:0]      nres_r, nres_nxt;
  logic            push_idx_r, push_idx_nxt;
  result_t         res_r [2];
  result_t         res_nxt [2];
  result_t         pend_r, pend_nxt;
  logic [7:0]      port_store_r [16];
  logic [7:0]      port_store_nxt [16];
  logic [7:0]      cur_hi_r, cur_hi_nxt;
  logic [7:0]      cur_lo_r, cur_lo_nxt;
  logic            out_valid_r, out_valid_nxt;
  result_t         out_res_r, out_res_nxt;
  logic            out_last_r, out_last_nxt;

  logic [14:0]     cur_ba;
  logic [WAW-1:0]  ram_addr;
  logic            ram_we;
  logic [15:0]     ram_wdata;
  logic [15:0]     ram_rdata;
  logic [7:0]      old_byte;
  logic [7:0]      new_byte;
  logic [15:0]     new_word;
  logic            in_ram;
  logic            changed;
  logic            visible;
  logic            more_byte;
  logic            out_free;
  logic            div_start;
  logic [POS_W-1:0] div_num;
  div_out_t        div_res;

  assign cur_ba    = (state_r == S_IDLE) ? {1'b0, in_addr}
                                         : {1'b0, addr_r} + {14'd0, byte_sel_r};
  assign ram_addr  = (state_r == S_CLR) ? clr_idx_r : WAW'(cur_ba >> 1);
  assign old_byte  = cur_ba[0] ? ram_rdata[15:8] : ram_rdata[7:0];
  assign new_byte  = byte_sel_r ? data_r[15:8] : data_r[7:0];
  assign new_word  = cur_ba[0] ? {new_byte, ram_rdata[7:0]} : {ram_rdata[15:8], new_byte};
  assign in_ram    = {2'b00, cur_ba} < VRAM_LIM;
  assign changed   = in_ram && (old_byte != new_byte);
  assign visible   = cur_ba < VIS_LIM;
  assign more_byte = (cmd_r == CMD_VWORD) && !byte_sel_r;
  assign out_free  = !out_valid_r || !out_stall;

  mtd_ram #(
    .WIDTH(16),
    .DEPTH(WORDS)
  ) u_vram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  mtd_div #(
    .COLS(COLS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .res  (div_res)
  );

  always_comb begin
    logic [7:0]  idx;
    logic [15:0] new_pos;
    result_t     r;

    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    cmd_nxt        = cmd_r;
    addr_nxt       = addr_r;
    data_nxt       = data_r;
    byte_sel_nxt   = byte_sel_r;
    nres_nxt       = nres_r;
    push_idx_nxt   = push_idx_r;
    res_nxt        = res_r;
    pend_nxt       = pend_r;
    port_store_nxt = port_store_r;
    cur_hi_nxt     = cur_hi_r;
    cur_lo_nxt     = cur_lo_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_res_nxt    = out_res_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_wdata      = 16'd0;
    div_start      = 1'b0;
    div_num        = {2'b00, cur_ba[14:1]};
    idx            = port_store_r[PORT_INDEX];
    new_pos        = 16'd0;
    r              = '0;

    unique case (state_r)
      S_CLR: begin
        ram_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_cmd;
          addr_nxt     = in_addr;
          data_nxt     = in_data;
          byte_sel_nxt = 1'b0;
          nres_nxt     = 2'd0;
          push_idx_nxt = 1'b0;
          unique case (in_cmd)
            CMD_VBYTE, CMD_VWORD: begin
              state_nxt = S_MOD;
            end
            CMD_PWRITE: begin
              if (in_addr < PORT_COUNT) begin
                if (in_addr == PORT_DATA) begin
                  if (idx == CRTC_CUR_HI) begin
                    cur_hi_nxt = in_data[7:0];
                  end
                  if (idx == CRTC_CUR_LO) begin
                    cur_lo_nxt = in_data[7:0];
                  end
                  new_pos = {cur_hi_nxt, cur_lo_nxt};
                  if ((idx == CRTC_CUR_HI || idx == CRTC_CUR_LO) &&
                      new_pos != {cur_hi_r, cur_lo_r}) begin
                    div_start     = 1'b1;
                    div_num       = new_pos;
                    r.kind        = KIND_CURSOR;
                    pend_nxt      = r;
                    state_nxt     = S_DIV;
                  end
                end else begin
                  port_store_nxt[in_addr[3:0]] = in_data[7:0];
                end
              end
            end
            CMD_PREAD: begin
              r.kind    = KIND_READ;
              r.read_data = (in_addr < PORT_COUNT) ? port_store_r[in_addr[3:0]] : 8'd0;
              res_nxt[0] = r;
              nres_nxt   = 2'd1;
              state_nxt  = S_PUSH;
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        ram_we    = changed;
        ram_wdata = new_word;
        if (changed && visible) begin
          r.kind    = KIND_CELL;
          r.glyph   = shown_glyph(new_word[7:0]);
          r.bright  = new_word[11];
          r.fg_on   = |new_word[10:8];
          r.bg_on   = |new_word[14:12];
          pend_nxt  = r;
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else if (more_byte) begin
          byte_sel_nxt = 1'b1;
          state_nxt    = S_RD;
        end else begin
          state_nxt = (nres_r != 2'd0) ? S_PUSH : S_IDLE;
        end
      end
      S_DIV: begin
        if (div_res.valid) begin
          r                 = pend_r;
          r.col             = div_res.rem[6:0];
          r.row             = div_res.quo[9:0];
          res_nxt[nres_r[0]] = r;
          nres_nxt          = nres_r + 2'd1;
          if (pend_r.kind == KIND_CELL && more_byte) begin
            byte_sel_nxt = 1'b1;
            state_nxt    = S_RD;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r[push_idx_r];
          out_last_nxt  = ({1'b0, push_idx_r} + 2'd1) == nres_r;
          if (out_last_nxt) begin
            state_nxt    = S_IDLE;
            push_idx_nxt = 1'b0;
            nres_nxt     = 2'd0;
          end else begin
            push_idx_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_idx_r    <= '0;
      byte_sel_r   <= 1'b0;
      nres_r       <= 2'd0;
      push_idx_r   <= 1'b0;
      port_store_r <= '{default: 8'd0};
      cur_hi_r     <= 8'd0;
      cur_lo_r     <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      byte_sel_r   <= byte_sel_nxt;
      nres_r       <= nres_nxt;
      push_idx_r   <= push_idx_nxt;
      port_store_r <= port_store_nxt;
      cur_hi_r     <= cur_hi_nxt;
      cur_lo_r     <= cur_lo_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    addr_r     <= addr_nxt;
    data_r     <= data_nxt;
    res_r      <= res_nxt;
    pend_r     <= pend_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_kind      = out_res_r.kind;
  assign out_col       = out_res_r.col;
  assign out_row       = out_res_r.row;
  assign out_glyph     = out_res_r.glyph;
  assign out_bright    = out_res_r.bright;
  assign out_fg_on     = out_res_r.fg_on;
  assign out_bg_on     = out_res_r.bg_on;
  assign out_read_data = out_res_r.read_data;
  assign out_last      = out_last_r;

  `MTD_ASSERT_NOW(a_div_only_when_waiting, div_res.valid, state_r == S_DIV, "divide result arrived outside wait state")
  `MTD_ASSERT_NOW(a_push_has_result, state_r == S_PUSH, nres_r != 2'd0 && 2'(push_idx_r) < nres_r, "push without pending result")
  `MTD_ASSERT_NEXT(a_clear_once, state_r != S_CLR, state_r != S_CLR, "clearing pass restarted")

endmodule

// ===== sim/tb_mono_text_display_tracker_unit.sv =====
// self-checking testbench for mono_text_display_tracker_unit: directed and random bus traffic,
// shadow copies of video ram, crtc registers, port store and cursor predict every result
// depends on mtd_pkg and the unit under test
`timescale 1ns / 1ps

module tb_mono_text_display_tracker_unit;
  import mtd_pkg::*;

  localparam int CRTC_REG_COUNT = 16;
  localparam int PORT_SLOTS     = 16;
  localparam int TOTAL_ITEMS    = 1050;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 40;
  localparam int QUIET_LIMIT    = 40000;
  localparam int IDLE_PCT       = 6;

  typedef struct packed {
    result_t fields;
    logic    last;
  } display_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = CMD_VBYTE;
  logic [13:0] in_addr = '0;
  logic [15:0] in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [6:0]  out_col;
  logic [9:0]  out_row;
  logic [6:0]  out_glyph;
  logic        out_bright;
  logic        out_fg_on;
  logic        out_bg_on;
  logic [7:0]  out_read_data;
  logic        out_last;

  logic [7:0]  vram_copy [VRAM_BYTES_DEF];
  logic [7:0]  crtc_copy [CRTC_REG_COUNT];
  logic [7:0]  port_copy [PORT_SLOTS];
  logic [15:0] cursor_copy;

  display_event_t pending_events[$];
  display_event_t step_events[$];

  int mismatches = 0;
  int items_sent = 0;
  int cmd_count [4];
  int kind_count [3];
  int quiet_cycles = 0;
  int hold_left = 0;
  bit want_hold = 1'b0;
  bit no_idle = 1'b0;

  mono_text_display_tracker_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_addr       (in_addr),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_col       (out_col),
    .out_row       (out_row),
    .out_glyph     (out_glyph),
    .out_bright    (out_bright),
    .out_fg_on     (out_fg_on),
    .out_bg_on     (out_bg_on),
    .out_read_data (out_read_data),
    .out_last      (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    foreach (vram_copy[i]) vram_copy[i] = 8'd0;
    foreach (crtc_copy[i]) crtc_copy[i] = 8'd0;
    foreach (port_copy[i]) port_copy[i] = 8'd0;
    foreach (cmd_count[i]) cmd_count[i] = 0;
    foreach (kind_count[i]) kind_count[i] = 0;
    cursor_copy = 16'd0;
  end

  // display prediction

  function automatic logic [6:0] displayed_char(input logic [7:0] c);
    if (c == 8'd0) return GLYPH_SPACE;
    if (c < 8'd32 || c > 8'd127) return GLYPH_DOT;
    return c[6:0];
  endfunction

  function automatic void track_vram_byte(input int unsigned a, input logic [7:0] v);
    display_event_t ev;
    logic [7:0] ch;
    logic [7:0] at;
    int unsigned cell_idx;
    if (a >= VRAM_BYTES_DEF) return;
    if (vram_copy[a] == v) return;
    vram_copy[a] = v;
    if (a >= VISIBLE_BYTES_DEF) return;
    if (a[0]) begin
      ch = vram_copy[a - 1];
      at = v;
    end else begin
      ch = v;
      at = (a + 1 < VRAM_BYTES_DEF) ? vram_copy[a + 1] : 8'd0;
    end
    cell_idx = a >> 1;
    ev = '0;
    ev.fields.kind   = KIND_CELL;
    ev.fields.col    = 7'(cell_idx % COLS_DEF);
    ev.fields.row    = 10'(cell_idx / COLS_DEF);
    ev.fields.glyph  = displayed_char(ch);
    ev.fields.bright = at[3];
    ev.fields.fg_on  = |at[2:0];
    ev.fields.bg_on  = |at[6:4];
    step_events.push_back(ev);
  endfunction

  function automatic void track_crtc_write(input logic [7:0] idx, input logic [7:0] v);
    display_event_t ev;
    int unsigned pos;
    if (idx >= CRTC_REG_COUNT) return;
    crtc_copy[idx] = v;
    if (idx != CRTC_CUR_HI && idx != CRTC_CUR_LO) return;
    pos = {crtc_copy[CRTC_CUR_HI], crtc_copy[CRTC_CUR_LO]};
    if (pos == cursor_copy) return;
    cursor_copy = 16'(pos);
    ev = '0;
    ev.fields.kind = KIND_CURSOR;
    ev.fields.col  = 7'(pos % COLS_DEF);
    ev.fields.row  = 10'(pos / COLS_DEF);
    step_events.push_back(ev);
  endfunction

  function automatic void predict_access(input logic [1:0] cmd, input logic [13:0] addr,
                                         input logic [15:0] data);
    display_event_t ev;
    step_events.delete();
    case (cmd)
      CMD_VBYTE: track_vram_byte(addr, data[7:0]);
      CMD_VWORD: begin
        track_vram_byte(addr, data[7:0]);
        track_vram_byte(int'(addr) + 1, data[15:8]);
      end
      CMD_PWRITE: begin
        if (addr < PORT_COUNT) begin
          if (addr == PORT_DATA) track_crtc_write(port_copy[PORT_INDEX], data[7:0]);
          else port_copy[addr] = data[7:0];
        end
      end
      default: begin
        ev = '0;
        ev.fields.kind      = KIND_READ;
        ev.fields.read_data = (addr < PORT_COUNT) ? port_copy[addr] : 8'd0;
        step_events.push_back(ev);
      end
    endcase
    if (step_events.size() > 0) step_events[$].last = 1'b1;
    foreach (step_events[i]) pending_events.push_back(step_events[i]);
  endfunction

  // bus side

  task automatic send_access(input logic [1:0] cmd, input logic [13:0] addr,
                             input logic [15:0] data);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_addr  <= addr;
    in_data  <= data;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_access(cmd, addr, data);
    items_sent++;
    cmd_count[cmd]++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_access();
    int unsigned pick;
    logic [13:0] a;
    logic [15:0] d;
    pick = $urandom_range(99);
    d = 16'($urandom);
    if (pick < 35) begin
      a = 14'($urandom_range(VISIBLE_BYTES_DEF - 1));
      if ($urandom_range(9) == 0) d[7:0] = vram_copy[a];
      send_access(CMD_VBYTE, a, d);
    end else if (pick < 55) begin
      a = 14'($urandom_range(VISIBLE_BYTES_DEF - 1));
      send_access(CMD_VWORD, a, d);
    end else if (pick < 65) begin
      a = 14'($urandom);
      send_access($urandom_range(1) ? CMD_VWORD : CMD_VBYTE, a, d);
    end else if (pick < 80) begin
      // select a cursor register, then write it
      d[7:0] = $urandom_range(1) ? CRTC_CUR_HI : CRTC_CUR_LO;
      send_access(CMD_PWRITE, 14'(PORT_INDEX), d);
      d = 16'($urandom);
      if ($urandom_range(3) == 0) d[7:0] = crtc_copy[port_copy[PORT_INDEX]];
      send_access(CMD_PWRITE, PORT_DATA, d);
    end else if (pick < 88) begin
      a = ($urandom_range(7) == 0) ? 14'($urandom) : 14'($urandom_range(PORT_SLOTS - 1));
      send_access(CMD_PWRITE, a, d);
    end else begin
      a = ($urandom_range(7) == 0) ? 14'($urandom) : 14'($urandom_range(PORT_SLOTS - 1));
      send_access(CMD_PREAD, a, d);
    end
  endtask

  // result side

  always @(posedge clk) begin
    if (want_hold) begin
      hold_left = HOLD_CYCLES;
      want_hold = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    display_event_t ev;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("result kind %0d with no transaction waiting for it", out_kind);
        mismatches++;
      end else begin
        ev = pending_events.pop_front();
        check_field("kind", ev.fields.kind, out_kind);
        check_field("col", ev.fields.col, out_col);
        check_field("row", ev.fields.row, out_row);
        check_field("glyph", ev.fields.glyph, out_glyph);
        check_field("bright", ev.fields.bright, out_bright);
        check_field("fg_on", ev.fields.fg_on, out_fg_on);
        check_field("bg_on", ev.fields.bg_on, out_bg_on);
        check_field("read_data", ev.fields.read_data, out_read_data);
        check_field("last", ev.last, out_last);
        if (ev.fields.kind < 3) kind_count[ev.fields.kind]++;
      end
    end
  end

  // watchdog: covers the ram clear after reset and the long receiver hold-off
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_mono_text_display_tracker_unit: errors");
      $finish;
    end
  end

  // tests

  task automatic test_cell_updates();
    send_access(CMD_VBYTE, 14'd0, 16'h0041);
    send_access(CMD_VBYTE, 14'd1, 16'h00ff);
    // unchanged byte
    send_access(CMD_VBYTE, 14'd1, 16'hffff);
    send_access(CMD_VBYTE, 14'd3999, 16'h0070);
    send_access(CMD_VBYTE, 14'd3998, 16'h007f);
    send_access(CMD_VBYTE, 14'd3998, 16'h0080);
    send_access(CMD_VBYTE, 14'd3998, 16'h001f);
    // outside the visible area
    send_access(CMD_VBYTE, 14'd4000, 16'h0055);
    send_access(CMD_VBYTE, 14'd16383, 16'h00aa);
  endtask

  task automatic test_word_writes();
    send_access(CMD_VWORD, 14'd0, 16'h0720);
    // high byte falls off the end of video ram
    send_access(CMD_VWORD, 14'd16383, 16'h12ab);
    send_access(CMD_VWORD, 14'd3999, 16'h0f00);
    send_access(CMD_VWORD, 14'd2, 16'h0000);
  endtask

  task automatic test_cursor_and_ports();
    send_access(CMD_PREAD, 14'd0, 16'h0000);
    send_access(CMD_PWRITE, 14'(PORT_INDEX), {8'h00, CRTC_CUR_HI});
    send_access(CMD_PWRITE, PORT_DATA, 16'h00ff);
    send_access(CMD_PWRITE, 14'(PORT_INDEX), {8'hff, CRTC_CUR_LO});
    send_access(CMD_PWRITE, PORT_DATA, 16'hffff);
    send_access(CMD_PWRITE, PORT_DATA, 16'h00ff);
    // index beyond the crtc register file
    send_access(CMD_PWRITE, 14'(PORT_INDEX), 16'h0010);
    send_access(CMD_PWRITE, PORT_DATA, 16'h0033);
    send_access(CMD_PWRITE, 14'd16383, 16'h0044);
    send_access(CMD_PREAD, 14'(PORT_INDEX), 16'hffff);
    send_access(CMD_PREAD, PORT_DATA, 16'h0000);
    send_access(CMD_PWRITE, 14'd15, 16'h00a5);
    send_access(CMD_PREAD, 14'd15, 16'h0000);
    send_access(CMD_PREAD, PORT_COUNT, 16'h0000);
    send_access(CMD_PREAD, 14'd16383, 16'h0000);
    send_access(CMD_PWRITE, 14'(PORT_INDEX), 16'h0003);
    send_access(CMD_PWRITE, PORT_DATA, 16'h005a);
  endtask

  task automatic test_backpressure();
    want_hold = 1'b1;
    repeat (40) send_random_access();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    while (items_sent < TOTAL_ITEMS) begin
      no_idle = (items_sent >= 400 && items_sent < 600);
      send_random_access();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cell_updates();
    test_word_writes();
    test_cursor_and_ports();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d transactions: %0d byte, %0d word, %0d port write, %0d port read",
             items_sent, cmd_count[CMD_VBYTE], cmd_count[CMD_VWORD], cmd_count[CMD_PWRITE],
             cmd_count[CMD_PREAD]);
    $display("checked %0d cell updates, %0d cursor moves, %0d port reads",
             kind_count[KIND_CELL], kind_count[KIND_CURSOR], kind_count[KIND_READ]);
    if (mismatches == 0) begin
      $display("tb_mono_text_display_tracker_unit: clean");
    end else begin
      $display("tb_mono_text_display_tracker_unit: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mtd_pkg.sv
sv/mtd_ram.sv
sv/mtd_div.sv
sv/mono_text_display_tracker_unit.sv
sim/tb_mono_text_display_tracker_unit.sv
